### rtl/assert_macros.svh
// Assertion macros shared by the LCD request formatter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define CLRF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define CLRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/clrf_pkg.sv
// Shared types and constants of the character LCD request formatter.
package clrf_pkg;

    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] FUNC_INIT   = 3'd0;
    localparam logic [2:0] FUNC_CMD    = 3'd1;
    localparam logic [2:0] FUNC_DATA   = 3'd2;
    localparam logic [2:0] FUNC_POS    = 3'd3;
    localparam logic [2:0] FUNC_NUMBER = 3'd4;
    localparam logic [2:0] FUNC_GLYPH  = 3'd5;

    localparam logic [7:0] CMD_FUNCSET = 8'b0011_1000;
    localparam logic [7:0] CMD_DISPON  = 8'b0000_1100;
    localparam logic [7:0] CMD_CLEAR   = 8'b0000_0001;
    localparam logic [7:0] CGRAM_BIT   = 8'd64;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    // Reciprocal of ten: floor(v / 10) == (v * DIV10_RECIP) >> DIV10_SHIFT for 32-bit v.
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEQ  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_seq;
        logic mul;
        logic div;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic req_ignore;
        logic req_number;
        logic seq_last;
        logic div_done;
        logic cnt_one;
        logic cnt_zero;
    } t_dp_sts;

endpackage

### rtl/clrf_ctrl.sv
// Controller state machine of the LCD request formatter.
`include "assert_macros.svh"

module clrf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  clrf_pkg::t_dp_sts i_sts,
    output clrf_pkg::t_dp_cmd o_cmd
);
    import clrf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.req_ignore) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.req_number) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_SEQ;
                    end
                end
            end
            ST_SEQ: begin
                o_cmd.emit_seq = 1'b1;
                if (i_sts.seq_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = i_sts.div_done ? ST_OUT : ST_MUL;
            end
            ST_OUT: begin
                o_cmd.pop = 1'b1;
                if (i_sts.cnt_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    `CLRF_ASSERT_NEXT(a_mul_then_div, r_state == ST_MUL, r_state == ST_DIV, "multiply not followed by remainder step")
    `CLRF_ASSERT_NEXT(a_div_done_out, (r_state == ST_DIV) && i_sts.div_done, r_state == ST_OUT, "conversion end did not start digit output")
    `CLRF_ASSERT_IMPL(a_pop_nonempty, o_cmd.pop, !i_sts.cnt_zero, "digit pop from an empty stack")

endmodule

### rtl/clrf_dp.sv
// Datapath of the LCD request formatter: request registers, divider, digit stack, output.
`include "assert_macros.svh"

module clrf_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clrf_pkg::t_dp_cmd i_cmd,
    output clrf_pkg::t_dp_sts o_sts,
    input  logic [2:0]        i_func,
    input  logic [31:0]       i_value,
    input  logic              i_line,
    input  logic [5:0]        i_column,
    input  logic [2:0]        i_slot,
    input  logic [63:0]       i_pattern,
    output logic              o_strobe,
    output logic              o_is_data,
    output logic [7:0]        o_bus_byte,
    output logic              o_last
);
    import clrf_pkg::*;

    logic [2:0]       r_func;
    logic [31:0]      r_v;
    logic             r_line;
    logic [5:0]       r_column;
    logic [2:0]       r_slot;
    logic [63:0]      r_pattern;
    logic [3:0]       r_step;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_prod;
    logic [3:0]       r_digits [MAX_DIGITS];

    logic             r_strobe;
    logic             r_is_data;
    logic [7:0]       r_byte;
    logic             r_last;

    logic             seq_is_data;
    logic [7:0]       seq_byte;
    logic             seq_last;
    logic [7:0]       ddram_byte;
    logic [2:0]       row;
    logic [28:0]      quot;
    logic [31:0]      quot_ext;
    logic [31:0]      quot_x10;
    logic [31:0]      rem_full;
    logic [3:0]       digit;

    // DDRAM address command: bit 7 set, line 1 adds 0x40, column in the low six bits.
    assign ddram_byte = {1'b1, r_line, r_column};
    assign row        = 3'(r_step - 4'd1);

    always_comb begin
        seq_is_data = 1'b0;
        seq_byte    = '0;
        seq_last    = 1'b1;
        case (r_func)
            FUNC_INIT: begin
                seq_last = (r_step == 4'd2);
                case (r_step)
                    4'd0:    seq_byte = CMD_FUNCSET;
                    4'd1:    seq_byte = CMD_DISPON;
                    default: seq_byte = CMD_CLEAR;
                endcase
            end
            FUNC_CMD: begin
                seq_byte = r_v[7:0];
            end
            FUNC_DATA: begin
                seq_is_data = 1'b1;
                seq_byte    = r_v[7:0];
            end
            FUNC_POS: begin
                seq_byte = ddram_byte;
            end
            FUNC_NUMBER: begin
                // Only a zero value takes this path; nonzero values go through the divider.
                seq_is_data = 1'b1;
                seq_byte    = ASCII_ZERO;
            end
            FUNC_GLYPH: begin
                seq_last = (r_step == 4'd10);
                if (r_step == 4'd0) begin
                    seq_byte = CGRAM_BIT | {2'b00, r_slot, 3'b000};
                end else if (r_step == 4'd9) begin
                    seq_byte = ddram_byte;
                end else if (r_step == 4'd10) begin
                    seq_is_data = 1'b1;
                    seq_byte    = {5'b00000, r_slot};
                end else begin
                    seq_is_data = 1'b1;
                    seq_byte    = r_pattern[{row, 3'b000} +: 8];
                end
            end
            default: begin
                seq_byte = '0;
            end
        endcase
    end

    assign quot     = r_prod[63:DIV10_SHIFT];
    assign quot_ext = {3'b000, quot};
    assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
    assign rem_full = r_v - quot_x10;
    assign digit    = rem_full[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_seq | i_cmd.pop;
            if (i_cmd.load) begin
                r_step <= '0;
                r_cnt  <= '0;
            end else begin
                if (i_cmd.emit_seq) begin
                    r_step <= r_step + 4'd1;
                end
                if (i_cmd.div) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end else if (i_cmd.pop) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_v       <= i_value;
            r_line    <= i_line;
            r_column  <= i_column;
            r_slot    <= i_slot;
            r_pattern <= i_pattern;
        end
        if (i_cmd.mul) begin
            r_prod <= r_v * DIV10_RECIP;
        end
        if (i_cmd.div) begin
            r_v <= quot_ext;
        end
        if (i_cmd.emit_seq) begin
            r_is_data <= seq_is_data;
            r_byte    <= seq_byte;
            r_last    <= seq_last;
        end else if (i_cmd.pop) begin
            r_is_data <= 1'b1;
            r_byte    <= ASCII_ZERO | {4'b0000, r_digits[0]};
            r_last    <= (r_cnt == CNT_W'(1));
        end
    end

    // Digit stack: the least significant digit is pushed first, so the top pops most
    // significant first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div) begin
            r_digits[0] <= digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_digits[i] <= r_digits[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_digits[i] <= r_digits[i+1];
            end
        end
    end

    assign o_sts.req_ignore = (i_func > FUNC_GLYPH);
    assign o_sts.req_number = (i_func == FUNC_NUMBER) && (i_value != 32'd0);
    assign o_sts.seq_last   = seq_last;
    assign o_sts.div_done   = (quot == '0) || (r_cnt == CNT_W'(MAX_DIGITS - 1));
    assign o_sts.cnt_one    = (r_cnt == CNT_W'(1));
    assign o_sts.cnt_zero   = (r_cnt == '0);

    assign o_strobe   = r_strobe;
    assign o_is_data  = r_is_data;
    assign o_bus_byte = r_byte;
    assign o_last     = r_last;

    `CLRF_ASSERT_NEXT(a_gap_after_last, r_strobe && r_last, !r_strobe, "write issued right after the final write of a request")
    `CLRF_ASSERT_IMPL(a_stack_room, i_cmd.div, r_cnt < CNT_W'(MAX_DIGITS), "digit pushed onto a full stack")

endmodule

### rtl/char_lcd_request_formatter_unit.sv
// Top level of the character LCD request formatter.
//
// A request is taken at a clock edge where i_start is high and o_busy is low. The block then
// issues its bus writes one per cycle, each shown on o_is_data, o_bus_byte and o_last for a
// single cycle under o_strobe, in the cycle after it is formed; the receiver cannot stall, so
// every strobed write must be taken when it appears. Init issues 3 writes, a raw byte or
// position request 1, and a custom glyph 11. A number request of zero is a single write like
// a raw data byte. A nonzero number request with d digits first runs d conversion rounds,
// each a 32 by 32 multiply by the reciprocal of ten and then the remainder and quotient
// update, then issues d writes, one per digit. Func codes 6 and 7 are accepted and produce
// no write.
module char_lcd_request_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_value,
    input  logic        i_line,
    input  logic [5:0]  i_column,
    input  logic [2:0]  i_slot,
    input  logic [63:0] i_pattern,
    output logic        o_strobe,
    output logic        o_is_data,
    output logic [7:0]  o_bus_byte,
    output logic        o_last
);
    import clrf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    clrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    clrf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_line     (i_line),
        .i_column   (i_column),
        .i_slot     (i_slot),
        .i_pattern  (i_pattern),
        .o_strobe   (o_strobe),
        .o_is_data  (o_is_data),
        .o_bus_byte (o_bus_byte),
        .o_last     (o_last)
    );

endmodule

### tb/char_lcd_write_tracker.sv
// Predicts the LCD bus writes of each accepted request and checks the block's strobed writes.
module char_lcd_write_tracker
    import clrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_value,
    input  logic        i_line,
    input  logic [5:0]  i_column,
    input  logic [2:0]  i_slot,
    input  logic [63:0] i_pattern,
    input  logic        i_strobe,
    input  logic        i_is_data,
    input  logic [7:0]  i_bus_byte,
    input  logic        i_last,
    output int          o_error_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  DDRAM_BIT    = 8'h80;
    localparam logic [7:0]  LINE1_OFFSET = 8'h40;
    localparam int unsigned RADIX        = 10;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } lcd_write_t;

    lcd_write_t expected_writes[$];
    int         error_count = 0;

    assign o_error_count = error_count;
    assign o_outstanding = expected_writes.size();

    function automatic lcd_write_t bus_write(input logic is_data, input logic [7:0] bus_byte);
        lcd_write_t w;
        w.is_data  = is_data;
        w.bus_byte = bus_byte;
        w.last     = 1'b0;
        return w;
    endfunction

    function automatic logic [7:0] ddram_address(input logic line, input logic [5:0] column);
        return DDRAM_BIT + (line ? LINE1_OFFSET : 8'h00) + {2'b00, column};
    endfunction

    // Appends the writes that one request puts on the bus, in bus order.
    task automatic predict_writes(input logic [2:0] func, input logic [31:0] value,
                                  input logic line, input logic [5:0] column,
                                  input logic [2:0] slot, input logic [63:0] pattern);
        lcd_write_t     writes[$];
        logic [7:0]     digits[$];
        logic [31:0]    rest;
        case (func)
            FUNC_INIT: begin
                writes.push_back(bus_write(1'b0, CMD_FUNCSET));
                writes.push_back(bus_write(1'b0, CMD_DISPON));
                writes.push_back(bus_write(1'b0, CMD_CLEAR));
            end
            FUNC_CMD:  writes.push_back(bus_write(1'b0, value[7:0]));
            FUNC_DATA: writes.push_back(bus_write(1'b1, value[7:0]));
            FUNC_POS:  writes.push_back(bus_write(1'b0, ddram_address(line, column)));
            FUNC_NUMBER: begin
                if (value == 32'd0) begin
                    writes.push_back(bus_write(1'b1, ASCII_ZERO));
                end else begin
                    rest = value;
                    // Only the lowest MAX_DIGITS digits survive a too small buffer.
                    while (rest != 32'd0 && digits.size() < MAX_DIGITS) begin
                        digits.push_front(8'(rest % RADIX));
                        rest = rest / RADIX;
                    end
                    foreach (digits[k]) writes.push_back(bus_write(1'b1, ASCII_ZERO + digits[k]));
                end
            end
            FUNC_GLYPH: begin
                writes.push_back(bus_write(1'b0, CGRAM_BIT + {2'b00, slot, 3'b000}));
                for (int row = 0; row < 8; row++)
                    writes.push_back(bus_write(1'b1, pattern[8*row +: 8]));
                writes.push_back(bus_write(1'b0, ddram_address(line, column)));
                writes.push_back(bus_write(1'b1, {5'b00000, slot}));
            end
            default: ;
        endcase
        if (writes.size() > 0) writes[writes.size()-1].last = 1'b1;
        foreach (writes[k]) expected_writes.push_back(writes[k]);
    endtask

    always @(posedge i_clk) begin
        lcd_write_t want;
        if (i_rst_n) begin
            // A write leaves before a request taken at the same edge can add to the queue.
            if (i_strobe) begin
                if (expected_writes.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected write: expected none, actual is_data=%0b byte=%02h last=%0b",
                             $time, i_is_data, i_bus_byte, i_last);
                end else begin
                    want = expected_writes.pop_front();
                    if (i_is_data !== want.is_data) begin
                        error_count++;
                        $display("%0t: is_data mismatch: expected %0b, actual %0b",
                                 $time, want.is_data, i_is_data);
                    end
                    if (i_bus_byte !== want.bus_byte) begin
                        error_count++;
                        $display("%0t: bus_byte mismatch: expected %02h, actual %02h",
                                 $time, want.bus_byte, i_bus_byte);
                    end
                    if (i_last !== want.last) begin
                        error_count++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, i_last);
                    end
                end
            end
            if (i_start && !i_busy)
                predict_writes(i_func, i_value, i_line, i_column, i_slot, i_pattern);
        end
    end

endmodule

### tb/char_lcd_request_formatter_unit_test.sv
// Stimulus, watchdog and verdict for the character LCD request formatter.
module char_lcd_request_formatter_unit_test;
    import clrf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int         RANDOM_ITEMS  = 225;
    localparam int         QUIET_LIMIT   = 1000;
    localparam int         TAIL_CYCLES   = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [2:0]  i_func;
    logic [31:0] i_value;
    logic        i_line;
    logic [5:0]  i_column;
    logic [2:0]  i_slot;
    logic [63:0] i_pattern;
    logic        o_strobe;
    logic        o_is_data;
    logic [7:0]  o_bus_byte;
    logic        o_last;
    int          error_count;
    int          outstanding;
    int          quiet_cycles = 0;
    bit          no_gaps      = 1'b0;

    char_lcd_request_formatter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_line     (i_line),
        .i_column   (i_column),
        .i_slot     (i_slot),
        .i_pattern  (i_pattern),
        .o_strobe   (o_strobe),
        .o_is_data  (o_is_data),
        .o_bus_byte (o_bus_byte),
        .o_last     (o_last)
    );

    char_lcd_write_tracker tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_line        (i_line),
        .i_column      (i_column),
        .i_slot        (i_slot),
        .i_pattern     (i_pattern),
        .i_strobe      (o_strobe),
        .i_is_data     (o_is_data),
        .i_bus_byte    (o_bus_byte),
        .i_last        (o_last),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_start && !o_busy) || o_strobe))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Holds the request on the inputs until the block takes it.
    task automatic issue_request(input logic [2:0] func, input logic [31:0] value,
                                 input logic line, input logic [5:0] column,
                                 input logic [2:0] slot, input logic [63:0] pattern);
        i_start   <= 1'b1;
        i_func    <= func;
        i_value   <= value;
        i_line    <= line;
        i_column  <= column;
        i_slot    <= slot;
        i_pattern <= pattern;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            i_start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Mostly back to back or short pauses, now and then a long one.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 55) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [63:0] any_pattern();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [5:0] any_column();
        if ($urandom_range(0, 9) == 0) return 6'($urandom_range(40, 63));
        return 6'($urandom_range(0, 39));
    endfunction

    // Numbers of a random digit count, so short and long conversions both occur.
    function automatic logic [31:0] any_number();
        int          digits;
        longint      low;
        if ($urandom_range(0, 15) == 0) return 32'd0;
        digits = $urandom_range(1, 10);
        if (digits == 10) return $urandom();
        low = 1;
        repeat (digits - 1) low = low * 10;
        return $urandom_range(32'(low * 10 - 1), 32'(low));
    endfunction

    task automatic directed_requests();
        issue_request(FUNC_INIT, $urandom(), 1'b0, 6'd0, 3'd0, any_pattern());
        issue_request(FUNC_CMD, 32'h0000_0000, 1'b1, 6'd63, 3'd7, 64'd0);
        issue_request(FUNC_CMD, 32'hFFFF_FFFF, 1'b0, 6'd0, 3'd0, '1);
        idle_for(2);
        issue_request(FUNC_DATA, 32'h0000_0000, 1'b0, 6'd5, 3'd2, any_pattern());
        issue_request(FUNC_DATA, 32'hABCD_EF5A, 1'b1, 6'd12, 3'd5, any_pattern());
        issue_request(FUNC_DATA, 32'h0000_00FF, 1'b0, 6'd1, 3'd1, any_pattern());
        issue_request(FUNC_POS, $urandom(), 1'b0, 6'd0, 3'd3, any_pattern());
        issue_request(FUNC_POS, $urandom(), 1'b1, 6'd39, 3'd4, any_pattern());
        issue_request(FUNC_POS, $urandom(), 1'b1, 6'd63, 3'd6, any_pattern());
        issue_request(FUNC_POS, $urandom(), 1'b0, 6'd40, 3'd0, any_pattern());
        issue_request(FUNC_NUMBER, 32'd0, 1'b0, 6'd0, 3'd0, any_pattern());
        issue_request(FUNC_NUMBER, 32'd1, 1'b1, 6'd2, 3'd1, any_pattern());
        idle_for(5);
        issue_request(FUNC_NUMBER, 32'd9, 1'b0, 6'd0, 3'd0, any_pattern());
        issue_request(FUNC_NUMBER, 32'd10, 1'b0, 6'd0, 3'd0, any_pattern());
        issue_request(FUNC_NUMBER, 32'd1_000_000_000, 1'b0, 6'd0, 3'd0, any_pattern());
        issue_request(FUNC_NUMBER, 32'hFFFF_FFFF, 1'b0, 6'd0, 3'd0, any_pattern());
        issue_request(FUNC_NUMBER, 32'd1_234_567_890, 1'b1, 6'd9, 3'd3, any_pattern());
        issue_request(FUNC_GLYPH, $urandom(), 1'b0, 6'd0, 3'd0, 64'd0);
        issue_request(FUNC_GLYPH, $urandom(), 1'b1, 6'd63, 3'd7, '1);
        issue_request(FUNC_GLYPH, $urandom(), 1'b1, 6'd39, 3'd4, 64'h0123_4567_89AB_CDEF);
        issue_request(FUNC_SPARE_LO, $urandom(), 1'b1, 6'd7, 3'd2, any_pattern());
        issue_request(FUNC_SPARE_HI, $urandom(), 1'b0, 6'd3, 3'd6, any_pattern());
        issue_request(FUNC_CMD, 32'h1234_5680, 1'b0, 6'd0, 3'd0, any_pattern());
    endtask

    task automatic random_requests();
        int          counted;
        int          pick;
        logic [2:0]  func;
        logic [31:0] value;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (counted == RANDOM_ITEMS / 2) begin
                // One edge first, so the item taken at this edge is already in the queue.
                i_start <= 1'b0;
                @(posedge i_clk);
                while (outstanding != 0) @(posedge i_clk);
            end
            pick  = $urandom_range(0, 99);
            value = $urandom();
            if (pick < 8)       func = FUNC_INIT;
            else if (pick < 20) func = FUNC_CMD;
            else if (pick < 32) func = FUNC_DATA;
            else if (pick < 44) func = FUNC_POS;
            else if (pick < 72) func = FUNC_NUMBER;
            else if (pick < 96) func = FUNC_GLYPH;
            else                func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
            if (func == FUNC_NUMBER) value = any_number();
            issue_request(func, value, 1'($urandom()), any_column(), 3'($urandom()),
                          any_pattern());
            if (func != FUNC_SPARE_LO && func != FUNC_SPARE_HI) counted++;
            idle_for(gap_length());
        end
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_start   <= 1'b0;
        i_func    <= FUNC_INIT;
        i_value   <= '0;
        i_line    <= 1'b0;
        i_column  <= '0;
        i_slot    <= '0;
        i_pattern <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_requests();
        random_requests();
        i_start <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/clrf_pkg.sv
rtl/clrf_ctrl.sv
rtl/clrf_dp.sv
rtl/char_lcd_request_formatter_unit.sv
tb/char_lcd_write_tracker.sv
tb/char_lcd_request_formatter_unit_test.sv
